/* rtl/core/fifo_replacement_key_cache_macros.svh */
// assertion macros for the key cache checker
`ifndef FIFO_REPLACEMENT_KEY_CACHE_MACROS_SVH
`define FIFO_REPLACEMENT_KEY_CACHE_MACROS_SVH

// same-cycle implication, disabled during reset
`define FKC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, no disable
`define FKC_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/fkc_pkg.sv */
// shared types and constants of the key cache
package fkc_pkg;

   localparam int unsigned KEY_LIMIT = 16384;
   localparam logic [7:0] ENTRIES_RESET = 8'd128;
   localparam logic [14:0] MAX_LEN_RESET = 15'd16384;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_RETURN = 1'b1;

   localparam logic [2:0] ADDR_ENTRIES = 3'd0;
   localparam logic [2:0] ADDR_MAX_LEN = 3'd4;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_RET_READ,
      ST_RET_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [7:0]  entries_in_use;
      logic [14:0] max_key_length;
   } cfg_type;

   typedef struct packed {
      logic        command;
      logic [63:0] key_hash;
      logic [23:0] key_length;
      logic [63:0] key_check;
      logic [15:0] handle_in;
      logic        cacheable;
   } item_type;

   typedef struct packed {
      logic [15:0] handle;
      logic [63:0] key_check;
      logic [13:0] key_length;
      logic [63:0] key_hash;
   } slot_type;

   typedef struct packed {
      logic        hit;
      logic [15:0] handle_out;
      logic        release_res;
      logic [15:0] release_handle;
   } result_type;

endpackage

/* rtl/core/fkc_ram.sv */
// single-port-write, registered-read memory
module fkc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 128
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/fkc_engine.sv */
// lookup scan and return sequencer around the slot memories
module fkc_engine #(
   parameter int ENTRIES = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  fkc_pkg::cfg_type   cfg,
   input  fkc_pkg::item_type  item,
   input  logic               item_valid,
   output logic               item_ready,
   input  logic               out_free,
   output logic               res_push,
   output fkc_pkg::result_type res
);

   localparam int IDX_W = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
   localparam int SLOT_W = $clog2(ENTRIES + 1) > 8 ? $clog2(ENTRIES + 1) : 8;
   localparam int DATA_W = $bits(fkc_pkg::slot_type);

   fkc_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic             issued_all_ff, issued_all_in;
   logic             cmp_valid_ff, cmp_valid_in;
   logic             cmp_last_ff, cmp_last_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0] highest_ff, highest_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   fkc_pkg::item_type   item_ff, item_in;
   fkc_pkg::result_type res_ff, res_in;

   logic [SLOT_W-1:0] slots;
   logic [SLOT_W-1:0] next_ptr;
   logic              usable;
   logic              accept;
   logic              match;

   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             vld_wr_en;
   logic [IDX_W-1:0] vld_wr_addr;
   logic             vld_wr_data;
   logic             vld_rd;
   logic             dat_wr_en;
   fkc_pkg::slot_type dat_wr, dat_rd;

   fkc_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_valid_ram (
      .clock   (clock),
      .wr_en   (vld_wr_en),
      .wr_addr (vld_wr_addr),
      .wr_data (vld_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (vld_rd)
   );

   fkc_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_slot_ram (
      .clock   (clock),
      .wr_en   (dat_wr_en),
      .wr_addr (addr_ff),
      .wr_data (dat_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (dat_rd)
   );

   assign slots = (SLOT_W'(cfg.entries_in_use) > SLOT_W'(ENTRIES))
                  ? SLOT_W'(ENTRIES) : SLOT_W'(cfg.entries_in_use);
   assign usable = (slots != '0)
                   && (item.key_length < 24'(cfg.max_key_length))
                   && (item.key_length < 24'(fkc_pkg::KEY_LIMIT));
   assign accept = item_valid && item_ready;
   assign match = vld_rd && (dat_rd.key_hash == item_ff.key_hash)
                  && (24'(dat_rd.key_length) == item_ff.key_length)
                  && (dat_rd.key_check == item_ff.key_check);
   assign next_ptr = SLOT_W'(addr_ff) + SLOT_W'(1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fkc_pkg::ST_CLEAR: begin
            if (clr_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = fkc_pkg::ST_IDLE;
            end
         end
         fkc_pkg::ST_IDLE: begin
            if (item_valid) begin
               if (!usable) begin
                  state_in = fkc_pkg::ST_DONE;
               end else if (item.command == fkc_pkg::CMD_LOOKUP) begin
                  state_in = fkc_pkg::ST_SCAN;
               end else if (item.cacheable) begin
                  state_in = fkc_pkg::ST_RET_READ;
               end else begin
                  state_in = fkc_pkg::ST_DONE;
               end
            end
         end
         fkc_pkg::ST_SCAN: begin
            if (cmp_valid_ff && (match || cmp_last_ff)) begin
               state_in = fkc_pkg::ST_DONE;
            end
         end
         fkc_pkg::ST_RET_READ: state_in = fkc_pkg::ST_RET_WRITE;
         fkc_pkg::ST_RET_WRITE: state_in = fkc_pkg::ST_DONE;
         fkc_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = fkc_pkg::ST_IDLE;
            end
         end
         default: state_in = fkc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      item_ready  = 1'b0;
      res_push    = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = addr_ff;
      vld_wr_en   = 1'b0;
      vld_wr_addr = addr_ff;
      vld_wr_data = 1'b0;
      dat_wr_en   = 1'b0;
      dat_wr.handle     = item_ff.handle_in;
      dat_wr.key_check  = item_ff.key_check;
      dat_wr.key_length = item_ff.key_length[13:0];
      dat_wr.key_hash   = item_ff.key_hash;
      unique case (state_ff)
         fkc_pkg::ST_CLEAR: begin
            vld_wr_en   = 1'b1;
            vld_wr_addr = clr_ff;
         end
         fkc_pkg::ST_IDLE: item_ready = 1'b1;
         fkc_pkg::ST_SCAN: begin
            rd_en   = !issued_all_ff;
            rd_addr = scan_ff;
            if (cmp_valid_ff && match) begin
               vld_wr_en   = 1'b1;
               vld_wr_addr = cmp_idx_ff;
            end
         end
         fkc_pkg::ST_RET_READ: rd_en = 1'b1;
         fkc_pkg::ST_RET_WRITE: begin
            vld_wr_en   = 1'b1;
            vld_wr_data = 1'b1;
            dat_wr_en   = 1'b1;
         end
         fkc_pkg::ST_DONE: res_push = out_free;
         default: item_ready = 1'b0;
      endcase
   end

   always_comb begin
      clr_in        = clr_ff;
      scan_in       = scan_ff;
      issued_all_in = issued_all_ff;
      cmp_valid_in  = 1'b0;
      cmp_last_in   = cmp_last_ff;
      cmp_idx_in    = cmp_idx_ff;
      highest_in    = highest_ff;
      ptr_in        = ptr_ff;
      addr_in       = addr_ff;
      item_in       = item_ff;
      res_in        = res_ff;
      if (state_ff == fkc_pkg::ST_CLEAR) begin
         clr_in = clr_ff + IDX_W'(1);
      end
      if (accept) begin
         item_in       = item;
         scan_in       = '0;
         issued_all_in = 1'b0;
         addr_in       = (SLOT_W'(ptr_ff) >= slots) ? '0 : ptr_ff;
         res_in        = '0;
         if (item.command == fkc_pkg::CMD_RETURN && !(usable && item.cacheable)) begin
            res_in.release_res    = 1'b1;
            res_in.release_handle = item.handle_in;
         end
      end
      if (state_ff == fkc_pkg::ST_SCAN) begin
         if (!issued_all_ff) begin
            cmp_valid_in  = 1'b1;
            cmp_idx_in    = scan_ff;
            cmp_last_in   = (scan_ff == highest_ff);
            issued_all_in = (scan_ff == highest_ff);
            scan_in       = scan_ff + IDX_W'(1);
         end
         if (cmp_valid_ff && match) begin
            res_in.hit        = 1'b1;
            res_in.handle_out = dat_rd.handle;
         end
      end
      if (state_ff == fkc_pkg::ST_RET_WRITE) begin
         res_in.release_res    = vld_rd;
         res_in.release_handle = vld_rd ? dat_rd.handle : '0;
         if (addr_ff > highest_ff) begin
            highest_in = addr_ff;
         end
         ptr_in = (next_ptr >= slots) ? '0 : next_ptr[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fkc_pkg::ST_CLEAR;
         clr_ff       <= '0;
         cmp_valid_ff <= 1'b0;
         highest_ff   <= '0;
         ptr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cmp_valid_ff <= cmp_valid_in;
         highest_ff   <= highest_in;
         ptr_ff       <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      issued_all_ff <= issued_all_in;
      cmp_last_ff   <= cmp_last_in;
      cmp_idx_ff    <= cmp_idx_in;
      addr_ff       <= addr_in;
      item_ff       <= item_in;
      res_ff        <= res_in;
   end

   assign res = res_ff;

endmodule

/* rtl/core/fifo_replacement_key_cache.sv */
// key cache top: register port, stream channels and output register
// lookup: scans from slot 0 to the highest used slot, one slot a cycle, and stops early on a hit
// return: read, write, result; a refused return or unusable key goes straight to the result
// one word in flight until its result is pushed; the next word is taken while a result waits
// reset: synchronous; a clearing pass over all ENTRIES slots zeroes the valid memory,
// during which no word is accepted; registers return to 128 and 16384
module fifo_replacement_key_cache #(
   parameter int ENTRIES = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [167:0] req_tdata,  // key_hash, key_length, key_check, handle_in
   input  logic [1:0]   req_tuser,  // command, cacheable
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,  // handle_out, release_handle
   output logic [1:0]   rsp_tuser,  // hit, release_res
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   fkc_pkg::cfg_type    cfg_ff, cfg_in;
   fkc_pkg::item_type   item;
   fkc_pkg::result_type res, rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;
   logic                res_push;
   logic                csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_paddr)
            fkc_pkg::ADDR_ENTRIES: cfg_in.entries_in_use = csr_pwdata[7:0];
            fkc_pkg::ADDR_MAX_LEN: cfg_in.max_key_length = csr_pwdata[14:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         fkc_pkg::ADDR_ENTRIES: csr_prdata = {24'd0, cfg_ff.entries_in_use};
         fkc_pkg::ADDR_MAX_LEN: csr_prdata = {17'd0, cfg_ff.max_key_length};
         default: csr_prdata = '0;
      endcase
   end

   assign item.command    = req_tuser[0];
   assign item.cacheable  = req_tuser[1];
   assign item.key_hash   = req_tdata[63:0];
   assign item.key_length = req_tdata[87:64];
   assign item.key_check  = req_tdata[151:88];
   assign item.handle_in  = req_tdata[167:152];

   assign out_free = !rsp_valid_ff || rsp_tready;

   fkc_engine #(.ENTRIES(ENTRIES)) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item       (item),
      .item_valid (req_tvalid),
      .item_ready (req_tready),
      .out_free   (out_free),
      .res_push   (res_push),
      .res        (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_push) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.entries_in_use <= fkc_pkg::ENTRIES_RESET;
         cfg_ff.max_key_length <= fkc_pkg::MAX_LEN_RESET;
         rsp_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.release_handle, rsp_ff.handle_out};
   assign rsp_tuser  = {rsp_ff.release_res, rsp_ff.hit};

endmodule

/* rtl/core/fkc_checker.sv */
// port-level checks of the key cache and their binding
`include "fifo_replacement_key_cache_macros.svh"

module fkc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   `FKC_ASSERT_NEXT(a_reset_blocks_input, clock, reset, !req_tready, "word accepted during clear")
   `FKC_ASSERT_IMPL(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready ##1 !reset, $stable(rsp_tdata) && $stable(rsp_tuser) && rsp_tvalid, "stalled result changed")
   `FKC_ASSERT_IMPL(a_hit_no_release, clock, reset, rsp_tvalid, !(rsp_tuser[0] && rsp_tuser[1]), "hit and release together")
   `FKC_ASSERT_IMPL(a_miss_handle_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata[15:0] == 16'd0, "handle on a miss")
   `FKC_ASSERT_IMPL(a_release_zero, clock, reset, rsp_tvalid && !rsp_tuser[1], rsp_tdata[31:16] == 16'd0, "release handle without release")

endmodule

bind fifo_replacement_key_cache fkc_checker u_fkc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
